[hw/rtl/msw_pkg.sv]
// ----------------------------------------------------------------------------
// msw_pkg
// Types and offset codes shared by the soft-switch register bank.
// ----------------------------------------------------------------------------
package msw_pkg;

	typedef enum logic {
		KIND_READ  = 1'b0,
		KIND_WRITE = 1'b1
	} kind_t;

	localparam logic [7:0] OFF_STORE80_OFF = 8'h00;
	localparam logic [7:0] OFF_STORE80_ON  = 8'h01;
	localparam logic [7:0] OFF_RDMAIN      = 8'h02;
	localparam logic [7:0] OFF_RDAUX       = 8'h03;
	localparam logic [7:0] OFF_WRMAIN      = 8'h04;
	localparam logic [7:0] OFF_WRAUX       = 8'h05;
	localparam logic [7:0] OFF_SLOTCX      = 8'h06;
	localparam logic [7:0] OFF_INTCX       = 8'h07;
	localparam logic [7:0] OFF_STDZP       = 8'h08;
	localparam logic [7:0] OFF_ALTZP       = 8'h09;
	localparam logic [7:0] OFF_INTC3       = 8'h0A;
	localparam logic [7:0] OFF_SLOTC3      = 8'h0B;
	localparam logic [7:0] OFF_RD_BANK2    = 8'h11;
	localparam logic [7:0] OFF_RD_LCRAM    = 8'h12;
	localparam logic [7:0] OFF_RD_RAMRD    = 8'h13;
	localparam logic [7:0] OFF_RD_RAMWRT   = 8'h14;
	localparam logic [7:0] OFF_RD_INTCX    = 8'h15;
	localparam logic [7:0] OFF_RD_ALTZP    = 8'h16;
	localparam logic [7:0] OFF_RD_SLOTC3   = 8'h17;
	localparam logic [7:0] OFF_RD_STORE80  = 8'h18;
	localparam logic [7:0] OFF_SHADOW      = 8'h35;
	localparam logic [7:0] OFF_STATE       = 8'h68;

	localparam logic [7:0] FLAG_BIT7 = 8'h80;

	typedef struct packed {
		logic       store80;
		logic       aux_read;
		logic       aux_write;
		logic       internal_cx_rom;
		logic       alt_zero_page;
		logic       slot_c3_rom;
		logic       lc_bank2;
		logic       lc_read;
		logic       rom_bank;
		logic       page2;
		logic [6:0] shadow_en;
	} flags_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] offset;
		logic [7:0] write_data;
	} access_t;

	typedef struct packed {
		logic       map_update;
		logic [7:0] read_data;
	} result_t;

endpackage

[hw/rtl/memory_soft_switch_bank_core.sv]
// ----------------------------------------------------------------------------
// memory_soft_switch_bank_core
// Soft-switch register bank for a 256-byte I/O page.
// ----------------------------------------------------------------------------
// Every accepted access gives exactly one result: the input register feeds
// the flag decode, and once the result side can advance, the result register
// loads and the flags update together. Accesses are taken every
// cycle as long as the result side keeps draining; the flag registers update
// in access order, so each result reflects all earlier accesses. All flags
// clear on reset.
module memory_soft_switch_bank_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // offset[7:0], write_data[15:8]
	input  logic        s_axis_tuser,  // kind (0 read, 1 write)
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata   // read_data[7:0], map_update[8], zero[15:9]
);
	import msw_pkg::*;

	access_t acc_s1;
	logic    vld_s1;
	result_t res;
	result_t res_q;
	logic    vld_q;
	logic    adv;
	logic    commit;

	assign adv           = !vld_q || m_axis_tready;
	assign commit        = adv && vld_s1;
	assign s_axis_tready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			acc_s1.kind       <= kind_t'(s_axis_tuser);
			acc_s1.offset     <= s_axis_tdata[7:0];
			acc_s1.write_data <= s_axis_tdata[15:8];
		end
	end

	msw_flag_bank u_flag_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.commit (commit),
		.acc    (acc_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {7'b0, res_q.map_update, res_q.read_data};

	// writes never return data
	a_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		commit && acc_s1.kind == KIND_WRITE |=> res_q.read_data == 8'h00)
		else $error("write access returned nonzero read data");

	// a read at the store80 clear offset requests no map update
	a_read_zero_no_update: assert property (@(posedge clk) disable iff (!arst_n)
		commit && acc_s1.kind == KIND_READ && acc_s1.offset == OFF_STORE80_OFF
		|=> !res_q.map_update)
		else $error("read at store80 clear offset raised map update");

	// a committed item always lands in the result register
	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> vld_q)
		else $error("committed access lost");

	// input stage never blocked while the result register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_q |-> s_axis_tready)
		else $error("input stalled with empty result register");

endmodule

[hw/rtl/msw_decode.sv]
// ----------------------------------------------------------------------------
// msw_decode
// Offset decode: next flag state, read data and map update for one access.
// ----------------------------------------------------------------------------
module msw_decode (
	input  msw_pkg::flags_t  flags,
	input  msw_pkg::access_t acc,
	output msw_pkg::flags_t  flags_nxt,
	output msw_pkg::result_t res
);
	import msw_pkg::*;

	logic       wr;
	logic [7:0] rd;

	assign wr = (acc.kind == KIND_WRITE);

	always_comb begin
		flags_nxt      = flags;
		rd             = '0;
		res.map_update = 1'b0;
		unique case (acc.offset)
			OFF_STORE80_OFF: begin
				if (wr) begin
					flags_nxt.store80 = 1'b0;
					res.map_update    = 1'b1;
				end
			end
			OFF_STORE80_ON: begin
				flags_nxt.store80 = 1'b1;
				res.map_update    = 1'b1;
			end
			OFF_RDMAIN: begin
				flags_nxt.aux_read = 1'b0;
				res.map_update     = 1'b1;
			end
			OFF_RDAUX: begin
				flags_nxt.aux_read = 1'b1;
				res.map_update     = 1'b1;
			end
			OFF_WRMAIN: begin
				flags_nxt.aux_write = 1'b0;
				res.map_update      = 1'b1;
			end
			OFF_WRAUX: begin
				flags_nxt.aux_write = 1'b1;
				res.map_update      = 1'b1;
			end
			OFF_SLOTCX: flags_nxt.internal_cx_rom = 1'b0;
			OFF_INTCX:  flags_nxt.internal_cx_rom = 1'b1;
			OFF_STDZP: begin
				flags_nxt.alt_zero_page = 1'b0;
				res.map_update          = 1'b1;
			end
			OFF_ALTZP: begin
				flags_nxt.alt_zero_page = 1'b1;
				res.map_update          = 1'b1;
			end
			OFF_INTC3:       flags_nxt.slot_c3_rom = 1'b0;
			OFF_SLOTC3:      flags_nxt.slot_c3_rom = 1'b1;
			OFF_RD_BANK2:    rd = flags.lc_bank2 ? FLAG_BIT7 : '0;
			OFF_RD_LCRAM:    rd = flags.lc_read ? FLAG_BIT7 : '0;
			OFF_RD_RAMRD:    rd = flags.aux_read ? FLAG_BIT7 : '0;
			OFF_RD_RAMWRT:   rd = flags.aux_write ? FLAG_BIT7 : '0;
			OFF_RD_INTCX:    rd = flags.internal_cx_rom ? FLAG_BIT7 : '0;
			OFF_RD_ALTZP:    rd = flags.alt_zero_page ? FLAG_BIT7 : '0;
			OFF_RD_SLOTC3:   rd = flags.slot_c3_rom ? FLAG_BIT7 : '0;
			OFF_RD_STORE80:  rd = flags.store80 ? FLAG_BIT7 : '0;
			OFF_SHADOW: begin
				if (wr) begin
					flags_nxt.shadow_en = ~acc.write_data[6:0];
					res.map_update      = 1'b1;
				end else begin
					rd = {1'b0, ~flags.shadow_en};
				end
			end
			OFF_STATE: begin
				if (wr) begin
					flags_nxt.internal_cx_rom = acc.write_data[0];
					flags_nxt.rom_bank        = acc.write_data[1];
					flags_nxt.lc_bank2        = acc.write_data[2];
					flags_nxt.lc_read         = acc.write_data[3];
					flags_nxt.aux_write       = acc.write_data[4];
					flags_nxt.aux_read        = acc.write_data[5];
					flags_nxt.page2           = acc.write_data[6];
					flags_nxt.alt_zero_page   = acc.write_data[7];
					res.map_update            = 1'b1;
				end else begin
					rd = {flags.alt_zero_page, flags.page2, flags.aux_read,
						flags.aux_write, ~flags.lc_read, flags.lc_bank2,
						flags.rom_bank, flags.internal_cx_rom};
				end
			end
			default: ;
		endcase
		res.read_data = wr ? 8'h00 : rd;
	end

endmodule

[hw/rtl/msw_flag_bank.sv]
// ----------------------------------------------------------------------------
// msw_flag_bank
// Mapping and shadow flag registers, updated once per committed access.
// ----------------------------------------------------------------------------
module msw_flag_bank (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             commit,
	input  msw_pkg::access_t acc,
	output msw_pkg::result_t res
);
	import msw_pkg::*;

	flags_t flags_q;
	flags_t flags_nxt;

	msw_decode u_decode (
		.flags     (flags_q),
		.acc       (acc),
		.flags_nxt (flags_nxt),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (commit) begin
			flags_q <= flags_nxt;
		end
	end

endmodule
